// File: rtl/assert_macros.svh
// Assertion macros for the level meter RTL.
// Clock is clk, synchronous reset rst disables checking.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression is never true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: rtl/alstat_pkg.sv
// Shared types and constants for the audio level batch/window meter.
// Used by alstat_div, alstat_ctrl and audio_level_batch_window_stats.
`timescale 1ns / 1ps

package alstat_pkg;

  localparam int MAX_BATCH  = 1024;
  localparam int NORM_SHIFT = 8;
  localparam int SMP_W      = 24;
  localparam int RUN_CNT_W  = 11;
  localparam int RUN_SUM_W  = 34;
  localparam int WIN_SUM_W  = 56;
  localparam int WIN_CNT_W  = 32;
  localparam int QUO_W      = 25;
  localparam int QSTEP_W    = 5;
  localparam logic [SMP_W-1:0] MEAN_MAX = 24'd8388608;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_BDIV,
    ST_WDIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic fold;
    logic div_start;
    logic div_sel_win;
    logic cap_b;
    logic cap_w;
    logic load_out;
  } ctrl_t;

endpackage

// File: rtl/alstat_div.sv
// Shared restoring divider with clamp to the mean limit, one quotient bit a cycle.
// Depends on alstat_pkg for widths and the clamp value.
`timescale 1ns / 1ps

module alstat_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [alstat_pkg::WIN_SUM_W-1:0]      dividend,
  input  logic [alstat_pkg::WIN_CNT_W-1:0]      divisor,
  output logic                                  done,
  output logic [alstat_pkg::SMP_W-1:0]          quotient
);

  localparam int HI_W = alstat_pkg::WIN_SUM_W - alstat_pkg::QUO_W;

  logic                              busy;
  logic [alstat_pkg::QSTEP_W-1:0]    cnt;
  logic [alstat_pkg::WIN_CNT_W-1:0]  rem;
  logic [alstat_pkg::QUO_W-1:0]      low;
  logic [alstat_pkg::QUO_W-1:0]      q;
  logic [alstat_pkg::WIN_CNT_W-1:0]  divr;

  logic                              ovf;
  logic [alstat_pkg::WIN_CNT_W:0]    shifted;
  logic [alstat_pkg::WIN_CNT_W+1:0]  diff;
  logic                              ge;

  // quotient would not fit in QUO_W bits: clamp right away
  assign ovf = {{(alstat_pkg::WIN_CNT_W-HI_W){1'b0}},
                dividend[alstat_pkg::WIN_SUM_W-1:alstat_pkg::QUO_W]} >= divisor;

  assign shifted = {rem, low[alstat_pkg::QUO_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divr};
  assign ge      = !diff[alstat_pkg::WIN_CNT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        divr <= divisor;
        if (ovf) begin
          q    <= '1;
          done <= 1'b1;
        end else begin
          rem  <= {{(alstat_pkg::WIN_CNT_W-HI_W){1'b0}},
                   dividend[alstat_pkg::WIN_SUM_W-1:alstat_pkg::QUO_W]};
          low  <= dividend[alstat_pkg::QUO_W-1:0];
          cnt  <= alstat_pkg::QSTEP_W'(alstat_pkg::QUO_W - 1);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? diff[alstat_pkg::WIN_CNT_W-1:0] : shifted[alstat_pkg::WIN_CNT_W-1:0];
        low <= {low[alstat_pkg::QUO_W-2:0], 1'b0};
        q   <= {q[alstat_pkg::QUO_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = (q > {1'b0, alstat_pkg::MEAN_MAX}) ? alstat_pkg::MEAN_MAX
                                                       : q[alstat_pkg::SMP_W-1:0];

endmodule

// File: rtl/alstat_ctrl.sv
// Sequencer for batch close: window fold, two divides, result load.
// Depends on alstat_pkg (state_t, ctrl_t) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module alstat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               close_hit,
  input  logic               div_done,
  input  logic               out_free,
  output alstat_pkg::ctrl_t  ctl
);

  alstat_pkg::state_t state;
  alstat_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alstat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      alstat_pkg::ST_IDLE: if (close_hit) state_next = alstat_pkg::ST_FOLD;
      alstat_pkg::ST_FOLD: state_next = alstat_pkg::ST_BDIV;
      alstat_pkg::ST_BDIV: if (div_done) state_next = alstat_pkg::ST_WDIV;
      alstat_pkg::ST_WDIV: if (div_done) state_next = alstat_pkg::ST_EMIT;
      alstat_pkg::ST_EMIT: if (out_free) state_next = alstat_pkg::ST_IDLE;
      default:             state_next = alstat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.busy = (state != alstat_pkg::ST_IDLE);
    case (state)
      alstat_pkg::ST_IDLE: ;
      alstat_pkg::ST_FOLD: begin
        ctl.fold      = 1'b1;
        ctl.div_start = 1'b1;
      end
      alstat_pkg::ST_BDIV: begin
        ctl.cap_b       = div_done;
        ctl.div_start   = div_done;
        ctl.div_sel_win = 1'b1;
      end
      alstat_pkg::ST_WDIV: begin
        ctl.div_sel_win = 1'b1;
        ctl.cap_w       = div_done;
      end
      alstat_pkg::ST_EMIT: ctl.load_out = out_free;
      default: ;
    endcase
  end

  `ASSERT_CLK(a_close_to_fold, close_hit |=> state == alstat_pkg::ST_FOLD, "close not followed by fold")
  `ASSERT_NEVER(a_done_in_div, div_done && !(state == alstat_pkg::ST_BDIV || state == alstat_pkg::ST_WDIV), "divider done outside divide states")
  `ASSERT_CLK(a_emit_to_idle, (state == alstat_pkg::ST_EMIT && out_free) |=> state == alstat_pkg::ST_IDLE, "emit did not return to idle")

endmodule

// File: rtl/audio_level_batch_window_stats.sv
// Top level of the audio level batch/window meter: run and window state, result register.
// Depends on alstat_pkg, alstat_ctrl, alstat_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A sample beat that does not close a batch, and a window clear, raise no stall, and
// the next beat may follow at once. A sample that closes its batch (marked last, or
// the MAX_BATCH-th) holds sample_stall high while the sequencer works: the FOLD state
// folds the batch into the window, then the shared divider forms the batch mean and
// the window mean at one quotient bit a cycle (the window mean ends early when it
// clamps), and the EMIT state loads the result register. The result register frees
// the input side: a pending result only delays the load of the next closing batch,
// and the input stays stalled until that load.

module audio_level_batch_window_stats (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic                action,
  input  logic signed [31:0]  raw_sample,
  input  logic                last_in_batch,
  output logic                result_valid,
  input  logic                result_stall,
  output logic signed [23:0]  batch_minimum,
  output logic signed [23:0]  batch_maximum,
  output logic [23:0]         batch_peak_to_peak,
  output logic [23:0]         batch_mean_abs,
  output logic [10:0]         batch_samples,
  output logic [31:0]         batch_sequence,
  output logic signed [23:0]  window_minimum,
  output logic signed [23:0]  window_maximum,
  output logic [23:0]         window_peak_to_peak,
  output logic [23:0]         window_mean_abs,
  output logic [31:0]         window_samples,
  output logic [31:0]         window_batches
);

  localparam int SMP_W = alstat_pkg::SMP_W;
  localparam int RCW   = alstat_pkg::RUN_CNT_W;
  localparam int RSW   = alstat_pkg::RUN_SUM_W;
  localparam int WSW   = alstat_pkg::WIN_SUM_W;
  localparam int WCW   = alstat_pkg::WIN_CNT_W;

  alstat_pkg::ctrl_t ctl;

  logic signed [SMP_W-1:0] run_minimum;
  logic signed [SMP_W-1:0] run_maximum;
  logic [RSW-1:0]          run_abs_sum;
  logic [RCW-1:0]          run_count;
  logic [31:0]             sequence_number;
  logic                    window_valid;
  logic signed [SMP_W-1:0] win_minimum;
  logic signed [SMP_W-1:0] win_maximum;
  logic [WSW-1:0]          win_abs_sum;
  logic [WCW-1:0]          win_sample_count;
  logic [WCW-1:0]          win_batch_count;
  logic [SMP_W-1:0]        mean_b;
  logic [SMP_W-1:0]        mean_w;

  logic                    in_fire;
  logic                    close_hit;
  logic                    out_free;
  logic signed [SMP_W-1:0] smp;
  logic [SMP_W-1:0]        smp_abs;
  logic [RCW-1:0]          run_count_inc;
  logic [WCW:0]            ws;
  logic [WSW:0]            wa;
  logic [WSW-1:0]          div_dividend;
  logic [WCW-1:0]          div_divisor;
  logic                    div_done;
  logic [SMP_W-1:0]        div_quotient;

  assign sample_stall  = ctl.busy;
  assign in_fire       = sample_valid && !sample_stall;
  assign out_free      = !result_valid || !result_stall;
  assign smp           = raw_sample[31:alstat_pkg::NORM_SHIFT];
  assign smp_abs       = smp[SMP_W-1] ? SMP_W'(-smp) : smp;
  assign run_count_inc = run_count + 1'b1;
  assign close_hit     = in_fire && (action == alstat_pkg::ACT_SAMPLE)
                         && (last_in_batch || run_count_inc == RCW'(alstat_pkg::MAX_BATCH));
  assign ws            = {1'b0, win_sample_count} + {{(WCW+1-RCW){1'b0}}, run_count};
  assign wa            = {1'b0, win_abs_sum} + {{(WSW+1-RSW){1'b0}}, run_abs_sum};

  assign div_dividend  = ctl.div_sel_win ? win_abs_sum : {{(WSW-RSW){1'b0}}, run_abs_sum};
  assign div_divisor   = ctl.div_sel_win ? win_sample_count
                                         : {{(WCW-RCW){1'b0}}, run_count};

  alstat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .close_hit (close_hit),
    .div_done  (div_done),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  alstat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      run_minimum      <= '0;
      run_maximum      <= '0;
      run_abs_sum      <= '0;
      run_count        <= '0;
      sequence_number  <= '0;
      window_valid     <= 1'b0;
      win_minimum      <= '0;
      win_maximum      <= '0;
      win_abs_sum      <= '0;
      win_sample_count <= '0;
      win_batch_count  <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (in_fire && (action == alstat_pkg::ACT_CLEAR)) begin
        window_valid     <= 1'b0;
        win_minimum      <= '0;
        win_maximum      <= '0;
        win_abs_sum      <= '0;
        win_sample_count <= '0;
        win_batch_count  <= '0;
      end else if (in_fire) begin
        if (run_count == '0) begin
          run_minimum <= smp;
          run_maximum <= smp;
          run_abs_sum <= {{(RSW-SMP_W){1'b0}}, smp_abs};
        end else begin
          if (smp < run_minimum) run_minimum <= smp;
          if (smp > run_maximum) run_maximum <= smp;
          run_abs_sum <= run_abs_sum + {{(RSW-SMP_W){1'b0}}, smp_abs};
        end
        run_count <= run_count_inc;
      end

      if (ctl.fold) begin
        sequence_number <= sequence_number + 1'b1;
        window_valid    <= 1'b1;
        if (!window_valid) begin
          win_minimum <= run_minimum;
          win_maximum <= run_maximum;
        end else begin
          if (run_minimum < win_minimum) win_minimum <= run_minimum;
          if (run_maximum > win_maximum) win_maximum <= run_maximum;
        end
        win_sample_count <= ws[WCW] ? '1 : ws[WCW-1:0];
        if (win_batch_count != '1) win_batch_count <= win_batch_count + 1'b1;
        win_abs_sum <= wa[WSW] ? '1 : wa[WSW-1:0];
      end

      if (ctl.load_out) begin
        result_valid <= 1'b1;
        run_minimum  <= '0;
        run_maximum  <= '0;
        run_abs_sum  <= '0;
        run_count    <= '0;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_b) mean_b <= div_quotient;
    if (ctl.cap_w) mean_w <= div_quotient;
    if (ctl.load_out) begin
      batch_minimum       <= run_minimum;
      batch_maximum       <= run_maximum;
      batch_peak_to_peak  <= SMP_W'(run_maximum - run_minimum);
      batch_mean_abs      <= mean_b;
      batch_samples       <= run_count;
      batch_sequence      <= sequence_number;
      window_minimum      <= win_minimum;
      window_maximum      <= win_maximum;
      window_peak_to_peak <= SMP_W'(win_maximum - win_minimum);
      window_mean_abs     <= mean_w;
      window_samples      <= win_sample_count;
      window_batches      <= win_batch_count;
    end
  end

  `ASSERT_CLK(a_run_cnt_max, run_count <= RCW'(alstat_pkg::MAX_BATCH), "batch count past limit")
  `ASSERT_CLK(a_load_free, ctl.load_out |-> (!result_valid || !result_stall), "result overwritten while held")
  `ASSERT_CLK(a_result_stable, (result_valid && result_stall) |=> (result_valid && $stable(batch_sequence)), "stalled result changed")

endmodule

// File: tb/sv/tb_audio_level_batch_window_stats.sv
// Testbench for audio_level_batch_window_stats: random batches of microphone words with
// window clears. An in-bench level meter predicts each result. Needs alstat_pkg and the DUT.
`timescale 1ns / 1ps

module tb_audio_level_batch_window_stats;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_BEATS   = 950;

  typedef struct packed {
    logic [23:0] b_min;
    logic [23:0] b_max;
    logic [23:0] b_p2p;
    logic [23:0] b_mean;
    logic [10:0] b_cnt;
    logic [31:0] b_seq;
    logic [23:0] w_min;
    logic [23:0] w_max;
    logic [23:0] w_p2p;
    logic [23:0] w_mean;
    logic [31:0] w_smp;
    logic [31:0] w_bat;
  } level_result_t;

  class level_meter_model;
    logic signed [23:0] bat_min, bat_max;
    logic [33:0]        bat_sum;
    int unsigned        bat_cnt;
    logic [31:0]        seq;
    bit                 win_live;
    logic signed [23:0] win_min, win_max;
    logic [55:0]        win_sum;
    logic [31:0]        win_smp, win_bat;
    level_result_t      pending_results[$];
    int                 mismatches;

    function new();
      bat_min = '0; bat_max = '0; bat_sum = '0; bat_cnt = 0; seq = '0;
      mismatches = 0;
      clear_window();
    endfunction

    function void clear_window();
      win_live = 1'b0; win_min = '0; win_max = '0; win_sum = '0; win_smp = '0; win_bat = '0;
    endfunction

    function logic [23:0] mean24(logic [63:0] sum, logic [63:0] cnt);
      logic [63:0] q;
      if (cnt == 0) return '0;
      q = sum / cnt;
      return (q > 64'(alstat_pkg::MEAN_MAX)) ? alstat_pkg::MEAN_MAX : q[23:0];
    endfunction

    // accepted input beat
    function void take_beat(bit act, logic [31:0] raw, bit lst);
      logic signed [23:0] s;
      int                 mag;
      logic [32:0]        smp_sum;
      level_result_t      r;
      if (act == alstat_pkg::ACT_CLEAR) begin
        clear_window();
        return;
      end
      s = raw[31:8];
      mag = (int'(s) < 0) ? -int'(s) : int'(s);
      if (bat_cnt == 0) begin
        bat_min = s; bat_max = s; bat_sum = '0;
      end else begin
        if (s < bat_min) bat_min = s;
        if (s > bat_max) bat_max = s;
      end
      bat_sum += 34'(mag);
      bat_cnt++;
      if (!lst && bat_cnt < alstat_pkg::MAX_BATCH) return;

      seq++;
      if (!win_live) begin
        win_live = 1'b1; win_min = bat_min; win_max = bat_max;
      end else begin
        if (bat_min < win_min) win_min = bat_min;
        if (bat_max > win_max) win_max = bat_max;
      end
      smp_sum = {1'b0, win_smp} + 33'(bat_cnt);
      win_smp = smp_sum[32] ? '1 : smp_sum[31:0];
      if (win_bat != '1) win_bat++;
      if ({56{1'b1}} - win_sum < 56'(bat_sum)) win_sum = '1;
      else win_sum += 56'(bat_sum);

      r.b_min  = bat_min;
      r.b_max  = bat_max;
      r.b_p2p  = 24'(int'(bat_max) - int'(bat_min));
      r.b_mean = mean24(64'(bat_sum), 64'(bat_cnt));
      r.b_cnt  = 11'(bat_cnt);
      r.b_seq  = seq;
      r.w_min  = win_min;
      r.w_max  = win_max;
      r.w_p2p  = 24'(int'(win_max) - int'(win_min));
      r.w_mean = mean24(64'(win_sum), 64'(win_smp));
      r.w_smp  = win_smp;
      r.w_bat  = win_bat;
      pending_results.push_back(r);

      bat_cnt = 0; bat_sum = '0; bat_min = '0; bat_max = '0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task cmp(string fld, logic [31:0] seq_no, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("batch %0d %s got %h want %h", seq_no, fld, got, want));
    endtask

    task check_result(level_result_t got);
      level_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with no batch pending, sequence %0d", got.b_seq));
        return;
      end
      want = pending_results.pop_front();
      cmp("batch_minimum",       want.b_seq, 32'(got.b_min),  32'(want.b_min));
      cmp("batch_maximum",       want.b_seq, 32'(got.b_max),  32'(want.b_max));
      cmp("batch_peak_to_peak",  want.b_seq, 32'(got.b_p2p),  32'(want.b_p2p));
      cmp("batch_mean_abs",      want.b_seq, 32'(got.b_mean), 32'(want.b_mean));
      cmp("batch_samples",       want.b_seq, 32'(got.b_cnt),  32'(want.b_cnt));
      cmp("batch_sequence",      want.b_seq, got.b_seq,       want.b_seq);
      cmp("window_minimum",      want.b_seq, 32'(got.w_min),  32'(want.w_min));
      cmp("window_maximum",      want.b_seq, 32'(got.w_max),  32'(want.w_max));
      cmp("window_peak_to_peak", want.b_seq, 32'(got.w_p2p),  32'(want.w_p2p));
      cmp("window_mean_abs",     want.b_seq, 32'(got.w_mean), 32'(want.w_mean));
      cmp("window_samples",      want.b_seq, got.w_smp,       want.w_smp);
      cmp("window_batches",      want.b_seq, got.w_bat,       want.w_bat);
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               sample_valid;
  logic               sample_stall;
  logic               action;
  logic signed [31:0] raw_sample;
  logic               last_in_batch;
  logic               result_valid;
  logic               result_stall;
  logic signed [23:0] batch_minimum;
  logic signed [23:0] batch_maximum;
  logic [23:0]        batch_peak_to_peak;
  logic [23:0]        batch_mean_abs;
  logic [10:0]        batch_samples;
  logic [31:0]        batch_sequence;
  logic signed [23:0] window_minimum;
  logic signed [23:0] window_maximum;
  logic [23:0]        window_peak_to_peak;
  logic [23:0]        window_mean_abs;
  logic [31:0]        window_samples;
  logic [31:0]        window_batches;

  level_meter_model meter;
  int               beats_sent;
  int               idle_cycles;

  audio_level_batch_window_stats u_top (
    .clk                 (clk),
    .rst                 (rst),
    .sample_valid        (sample_valid),
    .sample_stall        (sample_stall),
    .action              (action),
    .raw_sample          (raw_sample),
    .last_in_batch       (last_in_batch),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .batch_minimum       (batch_minimum),
    .batch_maximum       (batch_maximum),
    .batch_peak_to_peak  (batch_peak_to_peak),
    .batch_mean_abs      (batch_mean_abs),
    .batch_samples       (batch_samples),
    .batch_sequence      (batch_sequence),
    .window_minimum      (window_minimum),
    .window_maximum      (window_maximum),
    .window_peak_to_peak (window_peak_to_peak),
    .window_mean_abs     (window_mean_abs),
    .window_samples      (window_samples),
    .window_batches      (window_batches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: w[31:8] = 24'h800000;
      1: w[31:8] = 24'h7FFFFF;
      2: w[31:8] = 24'($urandom_range(0, 15));
      3: w[31:8] = -24'($urandom_range(1, 16));
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_beat(input bit act, input logic [31:0] raw, input bit lst, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      sample_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_valid  <= 1'b1;
    action        <= act;
    raw_sample    <= raw;
    last_in_batch <= lst;
    do @(posedge clk); while (sample_stall);
    meter.take_beat(act, raw, lst);
    beats_sent++;
  endtask

  // result side: stall bursts with quiet stretches in between
  initial begin : result_side
    int  span;
    bit  stl;
    result_stall = 1'b0;
    span = 0;
    stl  = 1'b0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        if ($urandom_range(0, 7) == 0) begin
          stl  = 1'b0;
          span = $urandom_range(100, 300);
        end else begin
          stl  = ($urandom_range(0, 2) == 0);
          span = stl ? pick_gap() + 1 : $urandom_range(1, 20);
        end
        result_stall <= stl;
      end
      span--;
    end
  end

  always @(posedge clk) begin : result_mon
    level_result_t seen;
    if (!rst && result_valid && !result_stall) begin
      seen = '{batch_minimum, batch_maximum, batch_peak_to_peak, batch_mean_abs,
               batch_samples, batch_sequence, window_minimum, window_maximum,
               window_peak_to_peak, window_mean_abs, window_samples, window_batches};
      meter.check_result(seen);
    end
  end

  always @(posedge clk) begin : watchdog
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int len, i, r;
    bit calm, lst;
    meter         = new();
    beats_sent    = 0;
    idle_cycles   = 0;
    rst           = 1'b1;
    sample_valid  = 1'b0;
    action        = alstat_pkg::ACT_SAMPLE;
    raw_sample    = '0;
    last_in_batch = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: clear on empty window, extremes, clear inside an open batch
    send_beat(alstat_pkg::ACT_CLEAR,  32'hFFFF_FFFF, 1'b1, 0);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'h7FFF_FFFF, 1'b1, 0);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'h8000_0000, 1'b1, 1);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'h8000_0000, 1'b0, 0);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'h7FFF_FF00, 1'b0, 0);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'h0000_00FF, 1'b1, 0);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'h8000_00FF, 1'b0, 2);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'h8000_0000, 1'b1, 0);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'h0000_0100, 1'b0, 0);
    send_beat(alstat_pkg::ACT_CLEAR,  32'h7FFF_FFFF, 1'b1, 0);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'hFFFF_FFFF, 1'b1, 0);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'h0000_0000, 1'b1, 3);
    send_beat(alstat_pkg::ACT_CLEAR,  32'h0000_0000, 1'b0, 0);
    send_beat(alstat_pkg::ACT_CLEAR,  32'h1234_5678, 1'b1, 0);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'hFFFF_FE00, 1'b0, 0);
    send_beat(alstat_pkg::ACT_SAMPLE, 32'h0000_01FF, 1'b1, 0);

    while (beats_sent < RANDOM_BEATS) begin
      calm = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      len = (r < 70) ? $urandom_range(1, 6) :
            (r < 95) ? $urandom_range(7, 40) : $urandom_range(41, 120);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 39) == 0)
          send_beat(alstat_pkg::ACT_CLEAR, $urandom, 1'($urandom_range(0, 1)),
                    calm ? 0 : pick_gap());
        lst = (i == len - 1) || ($urandom_range(0, 29) == 0);
        send_beat(alstat_pkg::ACT_SAMPLE, pick_word(), lst, calm ? 0 : pick_gap());
      end
    end
    @(negedge clk);
    sample_valid <= 1'b0;

    while (meter.pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (meter.mismatches == 0 && meter.pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
